// ----- rtl/dq_pkg.sv -----
`default_nettype none
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_NOP        = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;  // apply the item on the input ports
    logic rd;    // fetch front and back entries
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/dq_ctrl.sv -----
`default_nettype none
module dq_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output logic             out_valid,
  output dq_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign cmd.exec  = start && (state_r == S_IDLE);
  assign cmd.rd    = (state_r == S_READ);
  assign valid_nxt = cmd.rd;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dq_datapath.sv -----
`default_nettype none
module dq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dq_pkg::cmd_t                  cmd,
  input  wire logic [dq_pkg::MODE_W-1:0]     mode,
  input  wire logic [dq_pkg::DATA_W-1:0]     data_in,
  output logic      [dq_pkg::STATUS_W-1:0]   status,
  output logic      [dq_pkg::DATA_W-1:0]     front_value,
  output logic      [dq_pkg::DATA_W-1:0]     back_value,
  output logic      [dq_pkg::CNT_W-1:0]      count,
  output logic                               is_empty,
  output logic                               is_full
);

  localparam logic [dq_pkg::IDX_W-1:0] IDX_LAST = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
  localparam logic [dq_pkg::CNT_W-1:0] CNT_FULL = dq_pkg::CNT_W'(dq_pkg::DEPTH);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];

  logic [dq_pkg::IDX_W-1:0]    front_r, front_nxt;
  logic [dq_pkg::IDX_W-1:0]    back_r, back_nxt;
  logic [dq_pkg::CNT_W-1:0]    count_r, count_nxt;
  dq_pkg::status_t             status_r, status_nxt;
  logic [dq_pkg::DATA_W-1:0]   rd_front_r, rd_back_r;

  logic [dq_pkg::IDX_W-1:0]    front_dec, back_inc;
  logic                        empty_now, full_now;
  logic                        wr_en;
  logic [dq_pkg::IDX_W-1:0]    wr_addr;

  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
  assign empty_now = (count_r == '0);
  assign full_now  = (count_r == CNT_FULL);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = dq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    unique case (mode)
      dq_pkg::MODE_PUSH_FRONT: begin
        if (full_now) begin
          status_nxt = dq_pkg::ST_PUSH_FULL;
        end else begin
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          wr_en     = 1'b1;
          wr_addr   = front_dec;
        end
      end
      dq_pkg::MODE_PUSH_BACK: begin
        if (full_now) begin
          status_nxt = dq_pkg::ST_PUSH_FULL;
        end else begin
          back_nxt  = back_inc;
          count_nxt = count_r + 1'b1;
          wr_en     = 1'b1;
          wr_addr   = back_inc;
        end
      end
      dq_pkg::MODE_POP_FRONT: begin
        if (empty_now) begin
          status_nxt = dq_pkg::ST_POP_EMPTY;
        end else begin
          front_nxt = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      dq_pkg::MODE_POP_BACK: begin
        if (empty_now) begin
          status_nxt = dq_pkg::ST_POP_EMPTY;
        end else begin
          back_nxt  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      default: ;  // no operation, unused codes too
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      back_r   <= IDX_LAST;
      count_r  <= '0;
      status_r <= dq_pkg::ST_OK;
    end else if (cmd.exec) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // element store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= data_in;
    if (cmd.rd) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_r];
    end
  end

  assign status      = status_r;
  assign front_value = empty_now ? '0 : rd_front_r;
  assign back_value  = empty_now ? '0 : rd_back_r;
  assign count       = count_r;
  assign is_empty    = empty_now;
  assign is_full     = full_now;

endmodule
`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
`default_nettype none
// Bounded double-ended queue of signed 32-bit elements in a 16-entry ring.
//
// Input channel: drive in_mode / in_data_in and raise start; the item is
// taken at the clock edge where start is high and busy is low. Modes are
// push front, push back, pop front, pop back, no operation; 5..7 are no-ops.
//
// Result channel: one result per item, shown for exactly one cycle with
// out_valid high. It carries the status (ok, pop on empty, push on full),
// the front and back elements after the operation (zero when empty), the
// element count and the empty / full flags. The receiver cannot stall;
// each result must be taken in the cycle it is shown.
//
// Timing: indices, count and any store write update at the accept edge;
// the registered read ports load front and back at the next edge, where
// busy drops and out_valid rises. The result is taken at the edge after
// that. No new item is taken while busy is high, since the store read must
// follow its write.
//
// Reset (rst_n low, synchronous): queue empty, front index 0, back index
// at the last entry, no result pending. Store contents are not cleared.
module double_ended_queue (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [dq_pkg::MODE_W-1:0]  in_mode,
  input  wire logic signed [dq_pkg::DATA_W-1:0]  in_data_in,
  output logic                                   out_valid,
  output logic        [dq_pkg::STATUS_W-1:0]     out_status,
  output logic signed [dq_pkg::DATA_W-1:0]       out_front_value,
  output logic signed [dq_pkg::DATA_W-1:0]       out_back_value,
  output logic        [dq_pkg::COUNT_OUT_W-1:0]  out_count_out,
  output logic                                   out_is_empty,
  output logic                                   out_is_full
);

  dq_pkg::cmd_t                cmd;
  logic [dq_pkg::CNT_W-1:0]    count;
  logic [dq_pkg::DATA_W-1:0]   front_value, back_value;

  // sequencer: accept, then read, then strobe
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // indices, count, ring store and read registers
  dq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .mode        (in_mode),
    .data_in     (in_data_in),
    .status      (out_status),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .is_empty    (out_is_empty),
    .is_full     (out_is_full)
  );

  assign out_front_value = front_value;
  assign out_back_value  = back_value;
  // count port is fixed at 5 bits
  assign out_count_out   = dq_pkg::COUNT_OUT_W'(count);

endmodule
`default_nettype wire

// ----- verif/double_ended_queue_tb.sv -----
module double_ended_queue_tb;
  import dq_pkg::*;

  // Codes 5..7 are not assigned to any operation; the block treats them as no-ops.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_ZERO = '0;
  localparam logic signed [DATA_W-1:0] VAL_NEG1 = '1;

  // The queue's visible state after one operation. This is what one result item carries.
  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     empty;
    logic                     full;
  } deque_view_t;

  // Scoreboard: a shadow ring with its own indices. It replays each accepted operation
  // and keeps the resulting views in order until the block reports them.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]         head;
    logic [IDX_W-1:0]         tail;
    int unsigned              held;
    deque_view_t              views [$];
    int unsigned              mismatches;

    function new();
      head = '0;
      tail = IDX_W'(DEPTH - 1);
      held = 0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void note_op(logic [MODE_W-1:0] op, logic signed [DATA_W-1:0] value);
      deque_view_t v;
      v = '0;
      v.status = ST_OK;
      case (op)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (held == DEPTH) begin
            v.status = ST_PUSH_FULL;
          end else if (op == MODE_PUSH_FRONT) begin
            head = head - 1'b1;
            ring[head] = value;
            held++;
          end else begin
            tail = tail + 1'b1;
            ring[tail] = value;
            held++;
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (held == 0) begin
            v.status = ST_POP_EMPTY;
          end else if (op == MODE_POP_FRONT) begin
            head = head + 1'b1;
            held--;
          end else begin
            tail = tail - 1'b1;
            held--;
          end
        end
        default: ;
      endcase
      if (held != 0) begin
        v.front = ring[head];
        v.back  = ring[tail];
      end
      v.count = COUNT_OUT_W'(held);
      v.empty = (held == 0);
      v.full  = (held == DEPTH);
      views.push_back(v);
    endfunction

    function void check_result(deque_view_t got);
      deque_view_t want;
      if (views.size() == 0) begin
        flag($sformatf("result with nothing pending: st=%0d f=%0d b=%0d n=%0d",
                       got.status, got.front, got.back, got.count));
        return;
      end
      want = views.pop_front();
      if (got.status !== want.status || got.front !== want.front ||
          got.back !== want.back || got.count !== want.count ||
          got.empty !== want.empty || got.full !== want.full)
        flag($sformatf({"exp st=%0d f=%0d b=%0d n=%0d e=%0b u=%0b / ",
                        "got st=%0d f=%0d b=%0d n=%0d e=%0b u=%0b"},
                       want.status, want.front, want.back, want.count, want.empty,
                       want.full, got.status, got.front, got.back, got.count,
                       got.empty, got.full));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [MODE_W-1:0] in_mode = MODE_NOP;
  logic signed [DATA_W-1:0] in_data_in = '0;

  logic busy;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_back_value;
  logic [COUNT_OUT_W-1:0] out_count_out;
  logic out_is_empty;
  logic out_is_full;

  deque_scoreboard sb;
  bit idle_on;

  double_ended_queue dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_data_in(in_data_in),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_front_value(out_front_value),
    .out_back_value(out_back_value),
    .out_count_out(out_count_out),
    .out_is_empty(out_is_empty),
    .out_is_full(out_is_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are sampled at the edge itself. The block updates through NBAs, so
  // these reads see values from before the edge. A take is noted before a result is
  // checked; that ordering is harmless because a result never shares an edge with its
  // own take.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_op(in_mode, in_data_in);
      if (out_valid)
        sb.check_result('{status_t'(out_status), out_front_value, out_back_value,
                          out_count_out, out_is_empty, out_is_full});
    end
  end

  // Present one item and hold it until the block takes it. When idling is enabled,
  // each cycle before presenting has about a 29% chance of staying idle. A gap can
  // therefore land on either phase of the accept rhythm. Start stays high
  // between back-to-back items, so it is never lowered and raised in the same step.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] value);
    while (idle_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= op;
    in_data_in <= value;
    do @(posedge clk); while (busy);
  endtask

  // Data values: mostly random, with boundary values mixed in often enough to matter.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_ZERO;
      3: return VAL_NEG1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0] op;
    int unsigned push_pct;
    int unsigned r;
    sb = new();
    idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Start with pops on the empty queue, the no-op and the three spare
    // codes.
    send_op(MODE_POP_FRONT, VAL_MAX);
    send_op(MODE_POP_BACK, VAL_MIN);
    send_op(MODE_NOP, VAL_NEG1);
    for (int c = MODE_SPARE_FIRST; c <= MODE_SPARE_LAST; c++) send_op(MODE_W'(c), $urandom);
    // Fill the queue from both ends. The boundary values go in first, so they are
    // reported at both ends.
    for (int i = 0; i < DEPTH; i++) begin
      op = (i % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      case (i)
        0: send_op(op, VAL_MIN);
        1: send_op(op, VAL_MAX);
        2: send_op(op, VAL_ZERO);
        3: send_op(op, VAL_NEG1);
        default: send_op(op, $urandom);
      endcase
    end
    // Push on a full queue, from each end, then pop once from each end.
    send_op(MODE_PUSH_FRONT, VAL_MAX);
    send_op(MODE_PUSH_BACK, VAL_MIN);
    send_op(MODE_POP_FRONT, $urandom);
    send_op(MODE_POP_BACK, $urandom);

    // Random part. It runs in phases of 50 items, and each phase is biased toward
    // filling, balance or draining. This drives the queue repeatedly into full and
    // empty, and wraps the indices many times. Phases 2-5 form a long stretch with no
    // idling.
    for (int ph = 0; ph < 22; ph++) begin
      idle_on = !(ph >= 2 && ph <= 5);
      case ($urandom_range(2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(99);
        if (r < 2)
          op = MODE_NOP;
        else if (r < 4)
          op = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else if ($urandom_range(99) < push_pct)
          op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else
          op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        send_op(op, pick_value());
      end
    end
    start <= 1'b0;

    // Drain: wait until every pending result has been reported.
    for (int i = 0; i < 200 && sb.views.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.views.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.views.size()));

    if (sb.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog. It ends a hung run of about 1130 items and reports it as failed.
  initial begin
    #1200000;
    $display("Verification failed");
    $finish;
  end

endmodule
